/* rtl/rldec_pkg.sv */
package rldec_pkg;

    // default board geometry and run limit
    localparam int unsigned BOARD_WIDTH_DEF = 64;
    localparam int unsigned BOARD_DEPTH_DEF = 64;
    localparam int unsigned MAX_RUN_DEF     = 255;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_ROOM_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROOM_HEIGHT = 1'd1;

    // level text characters
    localparam logic [7:0] SYM_LINE       = 8'h7C;  // '|'
    localparam logic [7:0] SYM_BRICK      = 8'h23;  // '#'
    localparam logic [7:0] SYM_PLAYER_TGT = 8'h2B;  // '+'
    localparam logic [7:0] SYM_PLAYER     = 8'h40;  // '@'
    localparam logic [7:0] SYM_BOX_TGT    = 8'h2A;  // '*'
    localparam logic [7:0] SYM_TARGET     = 8'h2E;  // '.'
    localparam logic [7:0] SYM_SPACE      = 8'h20;  // ' '
    localparam logic [7:0] SYM_DASH       = 8'h2D;  // '-'
    localparam logic [7:0] SYM_UNDER      = 8'h5F;  // '_'
    localparam logic [7:0] SYM_BOX        = 8'h24;  // '$'
    localparam logic [7:0] SYM_STEEL      = 8'h3D;  // '='
    localparam logic [7:0] SYM_DIGIT0     = 8'h30;  // '0'
    localparam logic [7:0] SYM_DIGIT9     = 8'h39;  // '9'

    // tile codes
    localparam logic [2:0] TILE_BLANK   = 3'd0;
    localparam logic [2:0] TILE_STEEL   = 3'd1;
    localparam logic [2:0] TILE_BRICK   = 3'd2;
    localparam logic [2:0] TILE_BOX     = 3'd3;
    localparam logic [2:0] TILE_BOX_TGT = 3'd4;
    localparam logic [2:0] TILE_TARGET  = 3'd5;

    typedef struct packed {
        logic [6:0] room_width;
        logic [6:0] room_height;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  cur_col;
        logic [6:0]  cur_row;
        logic [7:0]  count;
        logic [11:0] pills;
        logic [6:0]  plr_col;
        logic [6:0]  plr_row;
    } t_state;

    typedef struct packed {
        logic [6:0]  column;
        logic [6:0]  row;
        logic [7:0]  run_length;
        logic [2:0]  tile;
        logic [11:0] pill_total;
        logic [6:0]  player_column;
        logic [6:0]  player_row;
        logic        off_board;
    } t_result;

    // clamp a 9-bit position sum to 127
    function automatic logic [6:0] sat127(input logic [8:0] v);
        return (v[8:7] != 2'b00) ? 7'h7F : v[6:0];
    endfunction

endpackage

/* rtl/rldec_in_if.sv */
interface rldec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       start_req;

    modport source (output valid, output symbol, output start_req, input ready);
    modport sink   (input valid, input symbol, input start_req, output ready);
endinterface

/* rtl/rldec_out_if.sv */
interface rldec_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  column;
    logic [6:0]  row;
    logic [7:0]  run_length;
    logic [2:0]  tile;
    logic [11:0] pill_total;
    logic [6:0]  player_column;
    logic [6:0]  player_row;
    logic        off_board;

    modport source (
        output valid, output column, output row, output run_length, output tile,
        output pill_total, output player_column, output player_row, output off_board,
        input ready
    );
    modport sink (
        input valid, input column, input row, input run_length, input tile,
        input pill_total, input player_column, input player_row, input off_board,
        output ready
    );
endinterface

/* rtl/rle_level_map_decoder_core.sv */
// a symbol accepted is held in the symbol register; its run descriptor is decoded from there
// combinationally and registered in the descriptor register when the step advances
// throughput: one symbol per cycle unless a waiting descriptor stalls; the state update is combinational
// a waiting descriptor stalls requests only once the symbol register holds a tile symbol
// reset (synchronous, active low): cursor, count, pill total, player position and
// room size go to zero, both stages empty
module rle_level_map_decoder_core import rldec_pkg::*; #(
    parameter int unsigned BOARD_WIDTH = BOARD_WIDTH_DEF,
    parameter int unsigned BOARD_DEPTH = BOARD_DEPTH_DEF,
    parameter int unsigned MAX_RUN     = MAX_RUN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rldec_in_if.sink              i_in,
    rldec_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    logic       r_in_valid;
    logic [7:0] r_in_symbol;
    logic       r_in_start;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       step_emit;
    logic       out_free;
    logic       step_adv;
    logic       in_ready;

    // decode step
    rldec_step #(
        .BOARD_WIDTH (BOARD_WIDTH),
        .BOARD_DEPTH (BOARD_DEPTH),
        .MAX_RUN     (MAX_RUN)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_symbol (r_in_symbol),
        .i_start  (r_in_start),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (n_out)
    );

    // flow control
    assign out_free = !r_out_valid || o_out.ready;
    assign step_adv = r_in_valid && (!step_emit || out_free);
    assign in_ready = !r_in_valid || step_adv;
    assign i_in.ready = in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROOM_WIDTH:  r_cfg.room_width  <= i_cfg_data;
                REG_ROOM_HEIGHT: r_cfg.room_height <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // control and decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step_adv) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= step_adv && step_emit;
            end
        end
    end

    // request and descriptor payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in_symbol <= i_in.symbol;
            r_in_start  <= i_in.start_req;
        end
        if (step_adv && step_emit) begin
            r_out <= n_out;
        end
    end

    // output channel
    assign o_out.valid         = r_out_valid;
    assign o_out.column        = r_out.column;
    assign o_out.row           = r_out.row;
    assign o_out.run_length    = r_out.run_length;
    assign o_out.tile          = r_out.tile;
    assign o_out.pill_total    = r_out.pill_total;
    assign o_out.player_column = r_out.player_column;
    assign o_out.player_row    = r_out.player_row;
    assign o_out.off_board     = r_out.off_board;

endmodule

/* rtl/rldec_step.sv */
module rldec_step import rldec_pkg::*; #(
    parameter int unsigned BOARD_WIDTH = BOARD_WIDTH_DEF,
    parameter int unsigned BOARD_DEPTH = BOARD_DEPTH_DEF,
    parameter int unsigned MAX_RUN     = MAX_RUN_DEF
) (
    input  t_cfg       i_cfg,
    input  t_state     i_state,
    input  logic [7:0] i_symbol,
    input  logic       i_start,
    output t_state     o_state,
    output logic       o_emit,
    output t_result    o_result
);

    localparam logic [6:0] BW7   = 7'(BOARD_WIDTH);
    localparam logic [6:0] BD7   = 7'(BOARD_DEPTH);
    localparam logic [7:0] MAXR8 = 8'(MAX_RUN);

    logic [6:0]  left;
    logic [6:0]  top;
    t_state      s;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [11:0] count_sum;
    logic [7:0]  run;
    logic        is_tile;
    logic        is_player;
    logic [2:0]  tile;
    logic [8:0]  col_end;
    logic [8:0]  row_end;
    logic [12:0] pill_sum;

    // centred room origin
    assign left = (i_cfg.room_width  >= BW7) ? 7'd0 : ((BW7 - i_cfg.room_width)  >> 1);
    assign top  = (i_cfg.room_height >= BD7) ? 7'd0 : ((BD7 - i_cfg.room_height) >> 1);

    // state after an optional restart
    always_comb begin
        s = i_state;
        if (i_start) begin
            s.cur_col = left;
            s.cur_row = top;
            s.count   = 8'd0;
            s.pills   = 12'd0;
        end
    end

    // repeat count arithmetic
    assign is_digit  = (i_symbol >= SYM_DIGIT0) && (i_symbol <= SYM_DIGIT9);
    assign digit_val = 4'(i_symbol - SYM_DIGIT0);
    assign count_sum = {1'b0, s.count, 3'b000} + {3'b000, s.count, 1'b0} + {8'd0, digit_val};
    assign run       = (s.count == 8'd0) ? 8'd1 : s.count;
    assign col_end   = {2'b00, s.cur_col} + {1'b0, run};
    assign row_end   = {2'b00, s.cur_row} + {1'b0, run};
    assign pill_sum  = {1'b0, s.pills} + {5'd0, run};

    // tile symbol decode
    always_comb begin
        is_tile   = 1'b1;
        is_player = 1'b0;
        tile      = TILE_BLANK;
        case (i_symbol)
            SYM_STEEL:      tile = TILE_STEEL;
            SYM_BRICK:      tile = TILE_BRICK;
            SYM_BOX:        tile = TILE_BOX;
            SYM_BOX_TGT:    tile = TILE_BOX_TGT;
            SYM_TARGET:     tile = TILE_TARGET;
            SYM_PLAYER_TGT: begin
                tile      = TILE_TARGET;
                is_player = 1'b1;
            end
            SYM_PLAYER:     is_player = 1'b1;
            SYM_SPACE,
            SYM_DASH,
            SYM_UNDER:      tile = TILE_BLANK;
            default:        is_tile = 1'b0;
        endcase
    end

    // next state and run descriptor
    always_comb begin
        o_state  = s;
        o_emit   = 1'b0;
        o_result = '0;
        if (is_digit) begin
            o_state.count = (count_sum > {4'd0, MAXR8}) ? MAXR8 : count_sum[7:0];
        end else if (i_symbol == SYM_LINE) begin
            o_state.cur_row = sat127(row_end);
            o_state.cur_col = left;
            o_state.count   = 8'd0;
        end else if (is_tile) begin
            if (is_player) begin
                o_state.plr_col = s.cur_col;
                o_state.plr_row = s.cur_row;
            end
            if (tile == TILE_TARGET) begin
                o_state.pills = pill_sum[12] ? 12'hFFF : pill_sum[11:0];
            end
            o_emit                 = 1'b1;
            o_result.column        = s.cur_col;
            o_result.row           = s.cur_row;
            o_result.run_length    = run;
            o_result.tile          = tile;
            o_result.pill_total    = o_state.pills;
            o_result.player_column = o_state.plr_col;
            o_result.player_row    = o_state.plr_row;
            o_result.off_board     = (col_end > 9'(BOARD_WIDTH)) || (s.cur_row >= BD7);
            o_state.cur_col        = sat127(col_end);
            o_state.count          = 8'd0;
        end
    end

endmodule

/* rtl/rldec_checker.sv */
module rldec_checker import rldec_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [6:0]  i_column,
    input logic [6:0]  i_row,
    input logic [7:0]  i_run_length,
    input logic [2:0]  i_tile,
    input logic [11:0] i_pill_total
);

    // no descriptor straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("descriptor valid right after reset");

    // a stalled descriptor holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_column)
            && $stable(i_row) && $stable(i_run_length) && $stable(i_tile)))
        else $error("stalled descriptor changed");

    // runs are never empty and tile codes are in range
    a_run_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_run_length != 8'd0 && i_tile <= TILE_TARGET))
        else $error("empty run or bad tile code");

    // a target run is already counted in the pill total
    a_pill_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_tile == TILE_TARGET) |-> (i_pill_total >= {4'd0, i_run_length}))
        else $error("pill total below target run");

endmodule

bind rle_level_map_decoder_core rldec_checker u_rldec_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_column     (o_out.column),
    .i_row        (o_out.row),
    .i_run_length (o_out.run_length),
    .i_tile       (o_out.tile),
    .i_pill_total (o_out.pill_total)
);

/* verif/rldec_run_checker.sv */
`timescale 1ns / 100ps

module rldec_run_checker import rldec_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rldec_in_if                   in_ch,
    rldec_out_if                  out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int unsigned REPORT_MAX = 10;

    // room size as last written
    logic [6:0]  room_w;
    logic [6:0]  room_h;

    // decoder state as predicted
    logic [6:0]  cur_col;
    logic [6:0]  cur_row;
    logic [7:0]  rep_count;
    logic [11:0] pills;
    logic [6:0]  plr_col;
    logic [6:0]  plr_row;

    t_result runs_due[$];
    int      mismatches = 0;
    int      runs_seen  = 0;

    function automatic logic [6:0] clamp_pos(input int unsigned v);
        return (v > 127) ? 7'd127 : 7'(v);
    endfunction

    // left or top edge that centres the room on the board
    function automatic logic [6:0] centre_gap(input int unsigned board, input int unsigned size);
        return (size >= board) ? 7'd0 : clamp_pos((board - size) >> 1);
    endfunction

    function automatic string run_text(input t_result r);
        return $sformatf("col %0d row %0d len %0d tile %0d pills %0d player %0d,%0d off %0b",
                         r.column, r.row, r.run_length, r.tile, r.pill_total,
                         r.player_column, r.player_row, r.off_board);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s", what);
    endfunction

    // advance the predicted state by one request, queue the run it produces
    task automatic decode_symbol(input logic [7:0] sym, input logic start);
        t_result     run_desc;
        int unsigned span;
        int unsigned sum;
        logic [2:0]  kind;
        logic        is_tile;
        logic        marks_player;
        if (start) begin
            cur_col   = centre_gap(BOARD_WIDTH_DEF, room_w);
            cur_row   = centre_gap(BOARD_DEPTH_DEF, room_h);
            rep_count = '0;
            pills     = '0;
        end
        // digits build the repeat count
        if (sym >= SYM_DIGIT0 && sym <= SYM_DIGIT9) begin
            sum = 10 * rep_count + (sym - SYM_DIGIT0);
            rep_count = (sum > MAX_RUN_DEF) ? 8'(MAX_RUN_DEF) : 8'(sum);
            return;
        end
        span = (rep_count != 0) ? rep_count : 1;
        // line break: down by the count, back to the left edge
        if (sym == SYM_LINE) begin
            cur_row   = clamp_pos(cur_row + span);
            cur_col   = centre_gap(BOARD_WIDTH_DEF, room_w);
            rep_count = '0;
            return;
        end
        is_tile      = 1'b1;
        marks_player = 1'b0;
        kind         = TILE_BLANK;
        case (sym)
            SYM_STEEL:   kind = TILE_STEEL;
            SYM_BRICK:   kind = TILE_BRICK;
            SYM_BOX:     kind = TILE_BOX;
            SYM_BOX_TGT: kind = TILE_BOX_TGT;
            SYM_TARGET:  kind = TILE_TARGET;
            SYM_PLAYER_TGT: begin
                kind         = TILE_TARGET;
                marks_player = 1'b1;
            end
            SYM_PLAYER: begin
                kind         = TILE_BLANK;
                marks_player = 1'b1;
            end
            SYM_SPACE, SYM_DASH, SYM_UNDER: kind = TILE_BLANK;
            default: is_tile = 1'b0;
        endcase
        // unknown characters leave everything alone
        if (!is_tile)
            return;
        if (marks_player) begin
            plr_col = cur_col;
            plr_row = cur_row;
        end
        if (kind == TILE_TARGET) begin
            sum   = pills + span;
            pills = (sum > 4095) ? 12'hFFF : 12'(sum);
        end
        run_desc.column        = cur_col;
        run_desc.row           = cur_row;
        run_desc.run_length    = 8'(span);
        run_desc.tile          = kind;
        run_desc.pill_total    = pills;
        run_desc.player_column = plr_col;
        run_desc.player_row    = plr_row;
        run_desc.off_board     = (cur_col + span > BOARD_WIDTH_DEF) ||
                                 (cur_row >= BOARD_DEPTH_DEF);
        runs_due.push_back(run_desc);
        cur_col   = clamp_pos(cur_col + span);
        rep_count = '0;
    endtask

    // compare one delivered run with the oldest prediction
    task automatic compare_run(input t_result got);
        t_result want;
        if (runs_due.size() == 0) begin
            note_mismatch($sformatf("unexpected tile run: %s", run_text(got)));
            return;
        end
        want = runs_due.pop_front();
        runs_seen++;
        if (got.column !== want.column || got.row !== want.row ||
            got.run_length !== want.run_length || got.tile !== want.tile ||
            got.pill_total !== want.pill_total || got.player_column !== want.player_column ||
            got.player_row !== want.player_row || got.off_board !== want.off_board) begin
            note_mismatch($sformatf("tile run %0d differs\n  expected %s\n  actual   %s",
                                    runs_seen, run_text(want), run_text(got)));
        end
    endtask

    // watch requests, config writes and runs at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            room_w    = '0;
            room_h    = '0;
            cur_col   = '0;
            cur_row   = '0;
            rep_count = '0;
            pills     = '0;
            plr_col   = '0;
            plr_row   = '0;
            runs_due.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                compare_run('{column: out_ch.column, row: out_ch.row,
                              run_length: out_ch.run_length, tile: out_ch.tile,
                              pill_total: out_ch.pill_total,
                              player_column: out_ch.player_column,
                              player_row: out_ch.player_row,
                              off_board: out_ch.off_board});
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROOM_WIDTH:  room_w = i_cfg_data;
                    REG_ROOM_HEIGHT: room_h = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                decode_symbol(in_ch.symbol, in_ch.start_req);
        end
        o_fail_count <= mismatches;
        o_pending    <= runs_due.size();
        o_checked    <= runs_seen;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
    import rldec_pkg::*;

    localparam int unsigned HANG_LIMIT   = 1000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 200;
    localparam int unsigned SETTLE_TICKS = 4;
    localparam logic [7:0]  STRAY_LO     = 8'h61;  // lower-case letters mean nothing
    localparam logic [7:0]  STRAY_HI     = 8'h7A;
    localparam logic [7:0]  STRAY_TOP    = 8'hFF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit in_gaps;
    bit out_stalls;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int symbols_sent = 0;
    int rooms_set    = 0;
    int fail_count;
    int pending;
    int runs_checked;

    rldec_in_if  in_ch();
    rldec_out_if out_ch();

    rle_level_map_decoder_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rldec_run_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (runs_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run sink with random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (out_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // hang detection: no request and no run for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d runs outstanding", quiet_cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bit decodable(input logic [7:0] sym);
        case (sym)
            SYM_LINE, SYM_BRICK, SYM_PLAYER_TGT, SYM_PLAYER, SYM_BOX_TGT, SYM_TARGET,
            SYM_SPACE, SYM_DASH, SYM_UNDER, SYM_BOX, SYM_STEEL: return 1'b1;
            default: return (sym >= SYM_DIGIT0 && sym <= SYM_DIGIT9);
        endcase
    endfunction

    function automatic logic [7:0] pick_tile();
        case ($urandom_range(0, 9))
            0:       return SYM_STEEL;
            1:       return SYM_BRICK;
            2:       return SYM_BOX;
            3:       return SYM_BOX_TGT;
            4:       return SYM_TARGET;
            5:       return SYM_PLAYER_TGT;
            6:       return SYM_PLAYER;
            7:       return SYM_SPACE;
            8:       return SYM_DASH;
            default: return SYM_UNDER;
        endcase
    endfunction

    // mostly the extremes and the sizes around the board size, with random sizes now and then
    function automatic logic [6:0] pick_room_size();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return 7'd64;
            2:       return 7'd127;
            3:       return 7'd63;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // one request, with an optional gap before it
    task automatic send_item(input logic [7:0] sym, input logic start);
        if (in_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.symbol    <= sym;
        in_ch.start_req <= start;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (decodable(sym))
            symbols_sent++;
    endtask

    // decimal repeat count, most significant digit first
    task automatic send_count(input int unsigned n);
        int unsigned scale;
        scale = 1;
        while (scale * 10 <= n) scale *= 10;
        while (scale > 0) begin
            send_item(SYM_DIGIT0 + 8'((n / scale) % 10), 1'b0);
            scale /= 10;
        end
    endtask

    // change room size once the decoder has gone quiet
    task automatic set_room(input logic [6:0] w, input logic [6:0] h);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        cfg_idx  <= REG_ROOM_WIDTH;
        cfg_data <= w;
        cfg_we   <= 1'b1;
        @(posedge i_clk);
        cfg_idx  <= REG_ROOM_HEIGHT;
        cfg_data <= h;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        rooms_set++;
    endtask

    // one level: start request, then rows of runs mixed with noise
    task automatic play_level(input int unsigned items);
        int          goal;
        int unsigned roll;
        goal = symbols_sent + items;
        send_item(pick_tile(), 1'b1);
        while (symbols_sent < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                if ($urandom_range(0, 2) == 0)
                    send_count($urandom_range(0, 12));
                send_item(pick_tile(), 1'b0);
            end else if (roll < 64) begin
                if ($urandom_range(0, 1) == 0)
                    send_count($urandom_range(0, 9));
                send_item(SYM_LINE, 1'b0);
            end else if (roll < 76) begin
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else if (roll < 84) begin
                // count interrupted by a stray character, kept for the next tile
                send_count($urandom_range(1, 99));
                send_item(8'($urandom_range(STRAY_LO, STRAY_HI)), 1'b0);
                send_item(pick_tile(), 1'b0);
            end else if (roll < 90) begin
                send_count($urandom_range(100, 999));
                send_item(($urandom_range(0, 2) == 0) ? SYM_LINE : pick_tile(), 1'b0);
            end else if (roll < 92) begin
                // enough full target runs to pin the pill total
                repeat ($urandom_range(17, 20)) begin
                    send_count(255);
                    send_item(($urandom_range(0, 1) == 0) ? SYM_TARGET : SYM_PLAYER_TGT, 1'b0);
                end
            end else begin
                send_item(($urandom_range(0, 1) == 0) ? pick_tile()
                                                      : SYM_DIGIT0 + 8'($urandom_range(0, 9)),
                          1'b1);
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int phase_goal;
        in_ch.valid     = 1'b0;
        in_ch.symbol    = '0;
        in_ch.start_req = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = REG_ROOM_WIDTH;
        cfg_data        = '0;
        in_gaps         = 1'b1;
        out_stalls      = 1'b1;
        i_rst_n         = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every symbol, count and cursor limits, stray characters
        set_room(7'd0, 7'd0);
        send_item(SYM_STEEL, 1'b1);
        send_item(SYM_BRICK, 1'b0);
        send_item(SYM_BOX, 1'b0);
        send_item(SYM_BOX_TGT, 1'b0);
        send_item(SYM_TARGET, 1'b0);
        send_item(SYM_PLAYER_TGT, 1'b0);
        send_item(SYM_PLAYER, 1'b0);
        send_item(SYM_SPACE, 1'b0);
        send_item(SYM_DASH, 1'b0);
        send_item(SYM_UNDER, 1'b0);
        send_item(SYM_LINE, 1'b0);
        send_count(999);
        send_item(SYM_BRICK, 1'b0);
        send_count(7);
        send_item(STRAY_TOP, 1'b0);
        send_item(STRAY_LO, 1'b0);
        send_item(SYM_BOX, 1'b0);
        send_count(0);
        send_item(SYM_TARGET, 1'b0);
        send_count(255);
        send_item(SYM_BRICK, 1'b0);
        send_count(200);
        send_item(SYM_LINE, 1'b0);
        send_item(SYM_DIGIT9, 1'b1);
        send_item(SYM_PLAYER, 1'b0);

        // random levels over a range of room sizes, idling off at the end
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       set_room(7'd64, 7'd64);
                1:       set_room(7'd127, 7'd127);
                2:       set_room(7'd1, 7'd63);
                default: set_room(pick_room_size(), pick_room_size());
            endcase
            in_gaps    = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
            out_stalls = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
            phase_goal = symbols_sent + PHASE_ITEMS;
            while (symbols_sent < phase_goal)
                play_level($urandom_range(20, 60));
        end

        // drain and settle
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("decoded %0d level characters across %0d room sizes", symbols_sent, rooms_set);
        $display("compared %0d tile runs, %0d mismatches, %0d outstanding",
                 runs_checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* rle_level_map_decoder_core.f */
rtl/rldec_pkg.sv
rtl/rldec_in_if.sv
rtl/rldec_out_if.sv
rtl/rldec_step.sv
rtl/rle_level_map_decoder_core.sv
rtl/rldec_checker.sv
verif/rldec_run_checker.sv
verif/tb.sv
